>>> rtl/pointer_length_cache_defines.svh
// ============================================================================
// Pointer length cache assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ============================================================================
`ifndef POINTER_LENGTH_CACHE_DEFINES_SVH
`define POINTER_LENGTH_CACHE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pointer_length_cache: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pointer_length_cache: next-cycle check failed");

`endif

>>> rtl/plc_pkg.sv
// ============================================================================
// Pointer length cache package
// Shared constants, operation codes and the victim LFSR step function.
// ============================================================================
package plc_pkg;

    localparam int ENTRIES_DEFAULT = 16;

    localparam logic [31:0] MIN_LEN_RESET = 32'd100;
    localparam logic [15:0] LFSR_SEED     = 16'hACE1;
    localparam logic [15:0] LFSR_MASK     = 16'hB400;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS  = 8'd1;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_DELETE = 2'd3
    } t_mode;

    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        logic [15:0] n;
        n = s >> 1;
        if (s[0]) begin
            n = n ^ LFSR_MASK;
        end
        return n;
    endfunction

endpackage

>>> rtl/plc_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
module plc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/plc_victim.sv
// ============================================================================
// Pointer length cache victim selector
// Advances the LFSR once per request and reduces it modulo the entry count
// with a reciprocal multiplication spread over the S_QUOT and S_REM states.
// ============================================================================
module plc_victim #(
    parameter int ENTRIES = plc_pkg::ENTRIES_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_done,
    output logic [$clog2(ENTRIES)-1:0] o_slot
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int SHIFT = 16 + IDX_W;
    localparam logic [17:0] RECIP = 18'(((64'd1 << SHIFT) / 64'(ENTRIES)) + 64'd1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_QUOT,
        S_REM
    } t_state;

    t_state           r_state;
    logic [15:0]      r_lfsr;
    logic [15:0]      r_quot;
    logic [IDX_W-1:0] r_rem;
    logic             r_done;

    logic [33:0]      n_prod;
    logic [33:0]      n_shift;
    logic [15:0]      n_quot;
    logic [24:0]      n_mult;
    logic [15:0]      n_diff;

    always_comb begin
        n_prod  = 34'(r_lfsr) * 34'(RECIP);
        n_shift = n_prod >> SHIFT;
        n_quot  = n_shift[15:0];
        n_mult  = 25'(r_quot) * 25'(ENTRIES);
        n_diff  = r_lfsr - n_mult[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lfsr  <= plc_pkg::LFSR_SEED;
            r_quot  <= '0;
            r_rem   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_lfsr  <= plc_pkg::lfsr_next(r_lfsr);
                        r_state <= S_QUOT;
                    end
                end
                S_QUOT: begin
                    r_quot  <= n_quot;
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_rem   <= n_diff[IDX_W-1:0];
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_slot = r_rem;

endmodule

>>> rtl/pointer_length_cache.sv
// A scanned command passes S_SCAN and S_ACT before its result strobe; an add that must
// evict also waits in S_EVICT for the victim. A zero key, or a lookup or add in bypass
// mode, skips the scan. One command at a time, set by the tag scan through one
// comparator at one RAM read per entry; for a scan, busy is high until the result strobe.
// Reset clears all valid bits, seeds the LFSR with 0xACE1 and loads the registers.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ============================================================================
// Pointer length cache
// Fully associative cache of lengths keyed by address with LFSR replacement.
// ============================================================================
`include "pointer_length_cache_defines.svh"

module pointer_length_cache #(
    parameter int ENTRIES = plc_pkg::ENTRIES_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_mode,
    input  logic [63:0]                    i_key,
    input  logic [31:0]                    i_length,
    input  logic signed [31:0]             i_delta,
    output logic                           o_done,
    output logic                           o_hit,
    output logic [31:0]                    o_cached_len,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [plc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_EVICT
    } t_state;

    t_state                r_state;
    plc_pkg::t_mode        r_mode;
    logic [63:0]           r_key;
    logic [31:0]           r_length;
    logic signed [31:0]    r_delta;
    logic [31:0]           r_min_len;
    logic                  r_bypass;
    logic [ENTRIES-1:0]    r_vbits;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_found;
    logic [IDX_W-1:0]      r_slot;
    logic [31:0]           r_len;
    logic                  r_empty_vld;
    logic [IDX_W-1:0]      r_empty_idx;
    logic                  r_done;
    logic                  r_hit;
    logic [31:0]           r_cached_len;

    logic [63:0]           w_tag_rdata;
    logic [31:0]           w_len_rdata;
    logic                  w_match;
    logic                  w_empty;
    logic                  w_tag_we;
    logic                  w_len_we;
    logic                  w_clr;
    logic [IDX_W-1:0]      w_waddr;
    logic [31:0]           w_len_wdata;
    logic                  w_victim_start;
    logic                  w_victim_done;
    logic [IDX_W-1:0]      w_victim_slot;
    logic                  w_accept;
    logic                  w_short;

    assign w_accept = start && !busy;
    assign w_short  = (i_key == 64'd0) || (r_bypass &&
                      ((i_mode == plc_pkg::MODE_LOOKUP) || (i_mode == plc_pkg::MODE_ADD)));

    assign w_match = r_cmp_vld && r_vbits[r_cmp_idx] && (w_tag_rdata == r_key);
    assign w_empty = r_cmp_vld && !r_vbits[r_cmp_idx];

    plc_ram #(
        .WIDTH (64),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_tag_we),
        .i_waddr (w_waddr),
        .i_wdata (r_key),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (w_tag_rdata)
    );

    plc_ram #(
        .WIDTH (32),
        .DEPTH (ENTRIES)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (w_len_we),
        .i_waddr (w_waddr),
        .i_wdata (w_len_wdata),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (w_len_rdata)
    );

    plc_victim #(
        .ENTRIES (ENTRIES)
    ) u_victim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_victim_start),
        .o_done  (w_victim_done),
        .o_slot  (w_victim_slot)
    );

    always_comb begin
        w_tag_we       = 1'b0;
        w_len_we       = 1'b0;
        w_clr          = 1'b0;
        w_waddr        = r_slot;
        w_len_wdata    = r_length;
        w_victim_start = 1'b0;
        unique case (r_state)
            S_ACT: begin
                unique case (r_mode)
                    plc_pkg::MODE_LOOKUP: begin
                    end
                    plc_pkg::MODE_ADD: begin
                        if (r_found) begin
                            if (r_length < r_min_len) begin
                                w_clr = 1'b1;
                            end else begin
                                w_len_we = 1'b1;
                            end
                        end else if (r_length > r_min_len) begin
                            if (r_empty_vld) begin
                                w_waddr  = r_empty_idx;
                                w_tag_we = 1'b1;
                                w_len_we = 1'b1;
                            end else begin
                                w_victim_start = 1'b1;
                            end
                        end
                    end
                    plc_pkg::MODE_UPDATE: begin
                        w_len_we    = r_found;
                        w_len_wdata = r_len + $unsigned(r_delta);
                    end
                    plc_pkg::MODE_DELETE: begin
                        w_clr = r_found;
                    end
                    default: begin
                    end
                endcase
            end
            S_EVICT: begin
                w_waddr  = w_victim_slot;
                w_tag_we = w_victim_done;
                w_len_we = w_victim_done;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_vbits      <= '0;
            r_min_len    <= plc_pkg::MIN_LEN_RESET;
            r_bypass     <= 1'b0;
            r_done       <= 1'b0;
            r_hit        <= 1'b0;
            r_cached_len <= '0;
            r_cnt        <= '0;
            r_cmp_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_empty_vld  <= 1'b0;
        end else begin
            r_done <= 1'b0;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    plc_pkg::REG_MIN_LEN: r_min_len <= i_cfg_data;
                    plc_pkg::REG_BYPASS:  r_bypass  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            if (w_tag_we) begin
                r_vbits[w_waddr] <= 1'b1;
            end else if (w_clr) begin
                r_vbits[w_waddr] <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode      <= plc_pkg::t_mode'(i_mode);
                        r_key       <= i_key;
                        r_length    <= i_length;
                        r_delta     <= i_delta;
                        r_cnt       <= '0;
                        r_cmp_vld   <= 1'b0;
                        r_found     <= 1'b0;
                        r_empty_vld <= 1'b0;
                        if (w_short) begin
                            r_done       <= 1'b1;
                            r_hit        <= 1'b0;
                            r_cached_len <= '0;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= 1'b1;
                    r_cmp_idx <= r_cnt[IDX_W-1:0];
                    if (w_match && !r_found) begin
                        r_found <= 1'b1;
                        r_slot  <= r_cmp_idx;
                        r_len   <= w_len_rdata;
                    end
                    if (w_empty) begin
                        r_empty_vld <= 1'b1;
                        r_empty_idx <= r_cmp_idx;
                    end
                    if (r_cnt == CNT_W'(ENTRIES)) begin
                        r_state <= S_ACT;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_ACT: begin
                    if (w_victim_start) begin
                        r_state <= S_EVICT;
                    end else begin
                        r_state      <= S_IDLE;
                        r_done       <= 1'b1;
                        r_hit        <= r_found;
                        r_cached_len <= (r_found && (r_mode == plc_pkg::MODE_LOOKUP)) ?
                                        r_len : 32'd0;
                    end
                end
                S_EVICT: begin
                    if (w_victim_done) begin
                        r_state      <= S_IDLE;
                        r_done       <= 1'b1;
                        r_hit        <= 1'b0;
                        r_cached_len <= '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_hit        = r_hit;
    assign o_cached_len = r_cached_len;
    assign o_cfg_ready  = 1'b1;

    `PLC_ASSERT_SAME(a_done_when_idle, o_done, !busy)
    `PLC_ASSERT_NEXT(a_scan_starts, w_accept && !w_short, busy && !o_done)
    `PLC_ASSERT_SAME(a_victim_in_evict, w_victim_done, r_state == S_EVICT)
    `PLC_ASSERT_SAME(a_victim_slot_range, w_victim_done, int'(w_victim_slot) < ENTRIES)
    `PLC_ASSERT_SAME(a_no_write_in_scan, r_state == S_SCAN, !w_tag_we && !w_len_we && !w_clr)

endmodule
